// File: hdl/i2cms_pkg.sv
// Shared types and codes for the I2C master transaction sequencer.
// Request/response payload structs, opcode, action, phase, error and TWI status codes.
// No dependencies.
package i2cms_pkg;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_START_WR  = 3'd1,
    OP_START_RD  = 3'd2,
    OP_STATUS    = 3'd3,
    OP_READBACK  = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_START    = 3'd1,
    ACT_ADDR     = 3'd2,
    ACT_ACK      = 3'd3,
    ACT_NACK     = 3'd4,
    ACT_STOP     = 3'd5,
    ACT_RELEASE  = 3'd6,
    ACT_REPSTART = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    PH_READY = 2'd0,
    PH_RX    = 2'd1,
    PH_TX    = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_ADDR_NACK = 3'd1,
    ERR_DATA_NACK = 3'd2,
    ERR_ARB_LOST  = 3'd3,
    ERR_BUS       = 3'd4
  } error_e;

  // TWI master status codes (low three bits masked off)
  localparam logic [7:0] ST_BUS_ERR     = 8'h00;
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_REP_START   = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;
  localparam logic [7:0] STATUS_MASK    = 8'hF8;

  localparam int unsigned LenW = 6;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [6:0]      device_address;
    logic [LenW-1:0] byte_count;
    logic            stop_at_end;
    logic [7:0]      bus_status;
    logic [7:0]      data_byte;
    logic [4:0]      buffer_slot;
  } req_t;

  typedef struct packed {
    logic            accepted;
    logic [2:0]      bus_action;
    logic [7:0]      tx_byte;
    logic            tx_valid;
    logic [1:0]      phase;
    logic [2:0]      error_code;
    logic [7:0]      read_data;
    logic [LenW-1:0] received_count;
  } rsp_t;

  // Decision result before the buffer read data is merged in
  typedef struct packed {
    logic            accepted;
    action_e         action;
    logic [7:0]      tx_lit;
    logic            tx_valid;
    logic            tx_from_buf;
    phase_e          phase;
    error_e          error;
    logic            rd_from_buf;
    logic [LenW-1:0] rcount;
  } ctrl_res_t;

endpackage

// File: hdl/i2cms_buffer.sv
// Byte buffer of the sequencer: one write port, two registered read ports.
// Depends on nothing but its parameters.
module i2cms_buffer #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [7:0]    rdata_a_o,
  output logic [7:0]    rdata_b_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_a_q;
  logic [7:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next request is taken
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: hdl/i2cms_ctrl.sv
// Transaction control of the sequencer: state registers and per-request decision logic.
// Depends on i2cms_pkg; drives the write/read ports of i2cms_buffer.
module i2cms_ctrl
  import i2cms_pkg::*;
#(
  parameter int unsigned BufLen = 32,
  parameter int unsigned AW     = 5,
  parameter int unsigned PosW   = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  req_t          req_i,
  output ctrl_res_t     res_o,
  output logic          buf_we_o,
  output logic [AW-1:0] buf_waddr_o,
  output logic [7:0]    buf_wdata_o,
  output logic [AW-1:0] buf_raddr_a_o,
  output logic [AW-1:0] buf_raddr_b_o
);

  localparam int unsigned CW = (PosW > LenW) ? PosW : LenW;
  localparam logic [CW-1:0] BufLenW = CW'(BufLen);

  phase_e          phase_q, phase_d;
  logic            stop_q, stop_d;
  logic            rep_q, rep_d;
  error_e          err_q, err_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [LenW-1:0] limit_q, limit_d;
  logic [LenW-1:0] reqlen_q, reqlen_d;
  logic [7:0]      addr_rw_q, addr_rw_d;

  logic [CW-1:0]   slot_w, pos_w, pos_d_w, limit_w, count_w, pos_after_w;
  logic [7:0]      status;
  logic            slot_ok, rd_op, store;

  assign slot_w  = CW'(req_i.buffer_slot);
  assign pos_w   = CW'(pos_q);
  assign limit_w = CW'(limit_q);
  assign count_w = CW'(req_i.byte_count);
  assign status  = req_i.bus_status & STATUS_MASK;
  assign slot_ok = slot_w < BufLenW;
  assign rd_op   = (opcode_e'(req_i.opcode) == OP_START_RD);

  assign buf_raddr_a_o = pos_w[AW-1:0];
  assign buf_raddr_b_o = slot_w[AW-1:0];
  assign buf_wdata_o   = req_i.data_byte;

  always_comb begin
    phase_d   = phase_q;
    stop_d    = stop_q;
    rep_d     = rep_q;
    err_d     = err_q;
    pos_d     = pos_q;
    limit_d   = limit_q;
    reqlen_d  = reqlen_q;
    addr_rw_d = addr_rw_q;
    res_o     = '0;
    buf_we_o  = 1'b0;
    buf_waddr_o = slot_w[AW-1:0];
    store     = 1'b0;

    unique case (opcode_e'(req_i.opcode))
      OP_LOAD: begin
        if (phase_q == PH_READY && slot_ok) begin
          buf_we_o       = 1'b1;
          res_o.accepted = 1'b1;
        end
      end
      OP_START_WR, OP_START_RD: begin
        if (phase_q == PH_READY && count_w <= BufLenW &&
            !(rd_op && req_i.byte_count == '0)) begin
          res_o.accepted = 1'b1;
          phase_d   = rd_op ? PH_RX : PH_TX;
          stop_d    = req_i.stop_at_end;
          err_d     = ERR_NONE;
          pos_d     = '0;
          reqlen_d  = req_i.byte_count;
          limit_d   = rd_op ? req_i.byte_count - LenW'(1) : req_i.byte_count;
          addr_rw_d = {req_i.device_address, rd_op};
          if (rep_q) begin
            // repeated start already on the bus: send the address byte now
            rep_d          = 1'b0;
            res_o.action   = ACT_ADDR;
            res_o.tx_lit   = {req_i.device_address, rd_op};
            res_o.tx_valid = 1'b1;
          end else begin
            res_o.action = ACT_START;
          end
        end
      end
      OP_STATUS: begin
        res_o.accepted = 1'b1;
        unique case (status)
          ST_START, ST_REP_START: begin
            res_o.tx_lit   = addr_rw_q;
            res_o.tx_valid = 1'b1;
            res_o.action   = ACT_ACK;
          end
          ST_SLA_W_ACK, ST_DATA_W_ACK: begin
            if (pos_w < limit_w && pos_w < BufLenW) begin
              res_o.tx_valid    = 1'b1;
              res_o.tx_from_buf = 1'b1;
              pos_d             = pos_q + PosW'(1);
              res_o.action      = ACT_ACK;
            end else begin
              phase_d = PH_READY;
              if (stop_q) begin
                res_o.action = ACT_STOP;
              end else begin
                rep_d        = 1'b1;
                res_o.action = ACT_REPSTART;
              end
            end
          end
          ST_SLA_W_NACK: begin
            err_d = ERR_ADDR_NACK; phase_d = PH_READY; res_o.action = ACT_STOP;
          end
          ST_DATA_W_NACK: begin
            err_d = ERR_DATA_NACK; phase_d = PH_READY; res_o.action = ACT_STOP;
          end
          ST_ARB_LOST: begin
            err_d = ERR_ARB_LOST; phase_d = PH_READY; res_o.action = ACT_RELEASE;
          end
          ST_DATA_R_ACK, ST_SLA_R_ACK: begin
            store        = (status == ST_DATA_R_ACK);
            res_o.action = ((store ? pos_after_w : pos_w) < limit_w) ? ACT_ACK : ACT_NACK;
          end
          ST_DATA_R_NACK: begin
            store   = 1'b1;
            phase_d = PH_READY;
            if (stop_q) begin
              res_o.action = ACT_STOP;
            end else begin
              rep_d        = 1'b1;
              res_o.action = ACT_REPSTART;
            end
          end
          ST_SLA_R_NACK: begin
            phase_d = PH_READY; res_o.action = ACT_STOP;
          end
          ST_BUS_ERR: begin
            err_d = ERR_BUS; phase_d = PH_READY; res_o.action = ACT_STOP;
          end
          default: begin
          end
        endcase
        // drop received bytes once the buffer is full
        if (store && pos_w < BufLenW) begin
          buf_we_o    = 1'b1;
          buf_waddr_o = pos_w[AW-1:0];
          pos_d       = pos_q + PosW'(1);
        end
      end
      OP_READBACK: begin
        if (slot_ok) begin
          res_o.accepted    = 1'b1;
          res_o.rd_from_buf = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res_o.phase = phase_d;
    res_o.error = err_d;
    pos_d_w     = CW'(pos_d);
    res_o.rcount = (pos_d_w < CW'(reqlen_d)) ? pos_d_w[LenW-1:0] : reqlen_d;
  end

  // position as seen after a possible store, for the ack/nack choice
  assign pos_after_w = (pos_w < BufLenW) ? pos_w + CW'(1) : pos_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_READY;
      stop_q    <= 1'b1;
      rep_q     <= 1'b0;
      err_q     <= ERR_NONE;
      pos_q     <= '0;
      limit_q   <= '0;
      reqlen_q  <= '0;
      addr_rw_q <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      stop_q    <= stop_d;
      rep_q     <= rep_d;
      err_q     <= err_d;
      pos_q     <= pos_d;
      limit_q   <= limit_d;
      reqlen_q  <= reqlen_d;
      addr_rw_q <= addr_rw_d;
    end
  end

endmodule

// File: hdl/i2c_master_transaction_sequencer_unit.sv
// Top level of the I2C master transaction sequencer.
// Depends on i2cms_pkg, i2cms_ctrl and i2cms_buffer.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------
//   request | in        | req_valid_i/req_ready_o | req_i (req_t)
//   result  | out       | rsp_valid_o/rsp_ready_i | rsp_o (rsp_t)
//
// One request per cycle unless the result stalls; results show in the next cycle.
// The decision is made in one pass from the request and the state registers and
// lands in the result register together with the buffer read data.
// A stalled result holds the register; a new request is taken in the same cycle
// that the waiting result is taken. Reset clears all control state; the buffer
// contents stay undefined until written.
module i2c_master_transaction_sequencer_unit
  import i2cms_pkg::*;
#(
  parameter int unsigned BUF_LEN = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned AW   = $clog2(BUF_LEN);
  localparam int unsigned PosW = $clog2(BUF_LEN + 1);

  logic          fire;
  ctrl_res_t     res_d, res_q;
  logic          rsp_valid_q;
  logic          buf_we;
  logic [AW-1:0] buf_waddr, buf_raddr_a, buf_raddr_b;
  logic [7:0]    buf_wdata, buf_rdata_a, buf_rdata_b;

  // take a request whenever the result register is empty or being emptied
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign fire        = req_valid_i && req_ready_o;

  i2cms_ctrl #(
    .BufLen (BUF_LEN),
    .AW     (AW),
    .PosW   (PosW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .req_i         (req_i),
    .res_o         (res_d),
    .buf_we_o      (buf_we),
    .buf_waddr_o   (buf_waddr),
    .buf_wdata_o   (buf_wdata),
    .buf_raddr_a_o (buf_raddr_a),
    .buf_raddr_b_o (buf_raddr_b)
  );

  // port A: next transmit byte at the current position; port B: read-back slot
  i2cms_buffer #(
    .Depth (BUF_LEN),
    .AW    (AW)
  ) u_buffer (
    .clk_i     (clk_i),
    .we_i      (buf_we && fire),
    .waddr_i   (buf_waddr),
    .wdata_i   (buf_wdata),
    .re_i      (fire),
    .raddr_a_i (buf_raddr_a),
    .raddr_b_i (buf_raddr_b),
    .rdata_a_o (buf_rdata_a),
    .rdata_b_o (buf_rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // payload register: hold while the result is stalled
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  // merge buffer read data into the result
  always_comb begin
    rsp_o.accepted       = res_q.accepted;
    rsp_o.bus_action     = res_q.action;
    rsp_o.tx_byte        = res_q.tx_from_buf ? buf_rdata_a : res_q.tx_lit;
    rsp_o.tx_valid       = res_q.tx_valid;
    rsp_o.phase          = res_q.phase;
    rsp_o.error_code     = res_q.error;
    rsp_o.read_data      = res_q.rd_from_buf ? buf_rdata_b : 8'h00;
    rsp_o.received_count = res_q.rcount;
  end

  assign rsp_valid_o = rsp_valid_q;

  // a taken request always shows a result in the next cycle
  a_fire_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> rsp_valid_o)
    else $error("request taken without a result");

  // a byte goes to the bus only with an address or ack action
  a_tx_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.tx_valid |->
      (rsp_o.bus_action == ACT_ADDR || rsp_o.bus_action == ACT_ACK))
    else $error("tx byte without matching bus action");

  // read-back data and transmit byte never appear together
  a_rd_tx_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && res_q.rd_from_buf |-> !rsp_o.tx_valid)
    else $error("read back and transmit in one result");

  // release, stop and repeated start all leave the sequencer ready
  a_end_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.bus_action == ACT_RELEASE || rsp_o.bus_action == ACT_STOP ||
                    rsp_o.bus_action == ACT_REPSTART) |-> rsp_o.phase == PH_READY)
    else $error("transaction end without ready phase");

endmodule

// File: tb/i2cms_txn_checker.sv
// Checker for the I2C master transaction sequencer: watches both channels, predicts each
// result from the accepted requests and compares it field by field.
// Depends on i2cms_pkg.
module i2cms_txn_checker
  import i2cms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  req_t        req_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  rsp_t        rsp_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int unsigned BufLen = 32;

  // Shadow of the sequencer state
  phase_e          phase_q;
  logic            stop_q;
  logic            repeat_q;
  error_e          error_q;
  logic [7:0]      byte_mem [BufLen];
  logic [LenW-1:0] pos_q;
  logic [LenW-1:0] limit_q;
  logic [LenW-1:0] len_q;
  logic [7:0]      addr_rw_q;

  rsp_t expected_results[$];

  // End of a transaction: stop, or leave a repeated start pending
  function automatic action_e wrap_up();
    phase_q = PH_READY;
    if (stop_q) return ACT_STOP;
    repeat_q = 1'b1;
    return ACT_REPSTART;
  endfunction

  // Drop bytes beyond the buffer end
  function automatic void stash_byte(logic [7:0] data);
    if (pos_q < BufLen) begin
      byte_mem[pos_q[4:0]] = data;
      pos_q = pos_q + 1'b1;
    end
  endfunction

  function automatic rsp_t advance_sequencer(req_t r);
    rsp_t       o;
    logic [7:0] code;
    logic       is_rd;
    o = '0;
    code = r.bus_status & STATUS_MASK;
    case (r.opcode)
      OP_LOAD: begin
        if (phase_q == PH_READY) begin
          byte_mem[r.buffer_slot] = r.data_byte;
          o.accepted = 1'b1;
        end
      end
      OP_START_WR, OP_START_RD: begin
        is_rd = (r.opcode == OP_START_RD);
        if (phase_q == PH_READY && r.byte_count <= BufLen && !(is_rd && r.byte_count == 0)) begin
          o.accepted = 1'b1;
          phase_q = is_rd ? PH_RX : PH_TX;
          stop_q = r.stop_at_end;
          error_q = ERR_NONE;
          pos_q = '0;
          len_q = r.byte_count;
          limit_q = is_rd ? r.byte_count - 1'b1 : r.byte_count;
          addr_rw_q = {r.device_address, is_rd};
          if (repeat_q) begin
            repeat_q = 1'b0;
            o.bus_action = ACT_ADDR;
            o.tx_byte = addr_rw_q;
            o.tx_valid = 1'b1;
          end else begin
            o.bus_action = ACT_START;
          end
        end
      end
      OP_STATUS: begin
        o.accepted = 1'b1;
        case (code)
          ST_START, ST_REP_START: begin
            o.tx_byte = addr_rw_q;
            o.tx_valid = 1'b1;
            o.bus_action = ACT_ACK;
          end
          ST_SLA_W_ACK, ST_DATA_W_ACK: begin
            if (pos_q < limit_q && pos_q < BufLen) begin
              o.tx_byte = byte_mem[pos_q[4:0]];
              o.tx_valid = 1'b1;
              pos_q = pos_q + 1'b1;
              o.bus_action = ACT_ACK;
            end else begin
              o.bus_action = wrap_up();
            end
          end
          ST_SLA_W_NACK: begin
            error_q = ERR_ADDR_NACK;
            phase_q = PH_READY;
            o.bus_action = ACT_STOP;
          end
          ST_DATA_W_NACK: begin
            error_q = ERR_DATA_NACK;
            phase_q = PH_READY;
            o.bus_action = ACT_STOP;
          end
          ST_ARB_LOST: begin
            error_q = ERR_ARB_LOST;
            phase_q = PH_READY;
            o.bus_action = ACT_RELEASE;
          end
          ST_DATA_R_ACK, ST_SLA_R_ACK: begin
            if (code == ST_DATA_R_ACK) stash_byte(r.data_byte);
            o.bus_action = (pos_q < limit_q) ? ACT_ACK : ACT_NACK;
          end
          ST_DATA_R_NACK: begin
            stash_byte(r.data_byte);
            o.bus_action = wrap_up();
          end
          ST_SLA_R_NACK: begin
            phase_q = PH_READY;
            o.bus_action = ACT_STOP;
          end
          ST_BUS_ERR: begin
            error_q = ERR_BUS;
            phase_q = PH_READY;
            o.bus_action = ACT_STOP;
          end
          default: ;
        endcase
      end
      OP_READBACK: begin
        o.read_data = byte_mem[r.buffer_slot];
        o.accepted = 1'b1;
      end
      default: ;
    endcase
    o.phase = phase_q;
    o.error_code = error_q;
    o.received_count = (pos_q < len_q) ? pos_q : len_q;
    return o;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    rsp_t want;
    if (!rst_ni) begin
      phase_q = PH_READY;
      stop_q = 1'b1;
      repeat_q = 1'b0;
      error_q = ERR_NONE;
      pos_q = '0;
      limit_q = '0;
      len_q = '0;
      addr_rw_q = '0;
      expected_results.delete();
      mismatches_o = 0;
      checked_o = 0;
    end else begin
      // A result is registered after its request is taken, so check before predicting
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          mismatches_o++;
        end else begin
          want = expected_results.pop_front();
          checked_o++;
          check_field("accepted", want.accepted, rsp_i.accepted);
          check_field("bus_action", want.bus_action, rsp_i.bus_action);
          check_field("tx_byte", want.tx_byte, rsp_i.tx_byte);
          check_field("tx_valid", want.tx_valid, rsp_i.tx_valid);
          check_field("phase", want.phase, rsp_i.phase);
          check_field("error_code", want.error_code, rsp_i.error_code);
          check_field("read_data", want.read_data, rsp_i.read_data);
          check_field("received_count", want.received_count, rsp_i.received_count);
        end
      end
      if (req_valid_i && req_ready_i) expected_results.push_back(advance_sequencer(req_i));
    end
    pending_o = expected_results.size();
  end

endmodule

// File: tb/testbench.sv
// Top of the I2C master transaction sequencer testbench: clock, reset, request stimulus,
// random result back-pressure, watchdog and verdict.
// Depends on i2cms_pkg, i2c_master_transaction_sequencer_unit and i2cms_txn_checker.
module testbench;
  import i2cms_pkg::*;

  localparam int unsigned RandomItems = 800;
  localparam int unsigned StallLimit  = 2000;
  // Opcodes outside the defined set, and the TWI no-information code
  localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
  localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
  localparam logic [7:0]  ST_NO_INFO   = 8'hF8;

  logic clk = 1'b0;
  logic rst_n;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned sent;
  logic        steady;

  always #5 clk = ~clk;

  i2c_master_transaction_sequencer_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  i2cms_txn_checker txn_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (req_valid),
    .req_ready_i  (req_ready),
    .req_i        (req),
    .rsp_valid_i  (rsp_valid),
    .rsp_ready_i  (rsp_ready),
    .rsp_i        (rsp),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Stall the result channel about 6 percent of the time, never during the steady stretch
  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(99) >= 6);
  end

  // Random request with every field scrambled; only the opcode is fixed
  function automatic req_t scramble(logic [2:0] op);
    logic [63:0] bits;
    req_t        r;
    bits = {$urandom, $urandom};
    r = bits[$bits(req_t)-1:0];
    r.opcode = op;
    return r;
  endfunction

  // Bus status event; the low three status bits are noise the block must ignore
  function automatic req_t bus_evt(logic [7:0] code);
    req_t r;
    r = scramble(OP_STATUS);
    r.bus_status = code | 8'($urandom_range(7));
    return r;
  endfunction

  function automatic req_t mk(logic [2:0] op, logic [6:0] addr, logic [5:0] cnt, logic stop,
                              logic [7:0] code, logic [7:0] data, logic [4:0] slot);
    req_t r;
    r.opcode = op;
    r.device_address = addr;
    r.byte_count = cnt;
    r.stop_at_end = stop;
    r.bus_status = code;
    r.data_byte = data;
    r.buffer_slot = slot;
    return r;
  endfunction

  // Mostly short transfers, a full buffer now and then, rarely an illegal length
  function automatic int pick_len(bit for_read);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return $urandom_range(33, 63);
    if (roll < 5 && for_read) return 0;
    if (roll < 15) return 32;
    return for_read ? $urandom_range(1, 8) : $urandom_range(0, 8);
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send(input req_t r);
    while (!steady && $urandom_range(99) < 6) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent++;
  endtask

  // Hold off new requests until every outstanding result is back
  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_txn();
    req_t        r;
    int          len;
    int unsigned roll;
    len = pick_len(1'b0);
    repeat ($urandom_range(3)) send(scramble(OP_LOAD));
    r = scramble(OP_START_WR);
    r.byte_count = 6'(len);
    send(r);
    send(bus_evt($urandom_range(1) ? ST_START : ST_REP_START));
    roll = $urandom_range(99);
    // Address nack ends the transfer before any data
    if (roll < 8) begin
      send(bus_evt(ST_SLA_W_NACK));
      return;
    end
    send(bus_evt(ST_SLA_W_ACK));
    for (int k = 0; k < len; k++) begin
      // Break off midway with a data nack or a lost arbitration
      if (roll < 16 && k == len / 2) begin
        send(bus_evt(roll < 12 ? ST_DATA_W_NACK : ST_ARB_LOST));
        return;
      end
      send(bus_evt(ST_DATA_W_ACK));
    end
  endtask

  task automatic read_txn();
    req_t        r;
    int          len;
    int          extra;
    int unsigned roll;
    len = pick_len(1'b1);
    r = scramble(OP_START_RD);
    r.byte_count = 6'(len);
    send(r);
    send(bus_evt($urandom_range(1) ? ST_START : ST_REP_START));
    roll = $urandom_range(99);
    if (roll < 8) begin
      send(bus_evt(ST_SLA_R_NACK));
      return;
    end
    send(bus_evt(ST_SLA_R_ACK));
    // Push extra data bytes now and then to overrun the buffer on full-length reads
    extra = (roll < 25) ? $urandom_range(1, 4) : 0;
    for (int k = 0; k < len - 1 + extra; k++) send(bus_evt(ST_DATA_R_ACK));
    send(bus_evt(ST_DATA_R_NACK));
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no handshake for %0d cycles", StallLimit);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_base;
    int unsigned roll;
    req_t        r;
    rst_n = 1'b0;
    req_valid = 1'b0;
    req = '0;
    steady = 1'b0;
    sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corner cases; only slots loaded here are ever read back or sent
    send(mk(OP_LOAD, 7'd0, 6'd0, 1'b0, 8'h00, 8'h00, 5'd0));
    send(mk(OP_LOAD, 7'd127, 6'd63, 1'b1, 8'hFF, 8'hFF, 5'd31));
    send(mk(OP_LOAD, 7'd0, 6'd0, 1'b0, 8'h00, 8'h5A, 5'd1));
    send(mk(OP_READBACK, 7'd0, 6'd0, 1'b0, 8'h00, 8'h00, 5'd31));
    // Reject: zero-length read, lengths beyond the buffer
    send(mk(OP_START_RD, 7'd5, 6'd0, 1'b1, 8'h00, 8'h00, 5'd0));
    send(mk(OP_START_WR, 7'd5, 6'd33, 1'b1, 8'h00, 8'h00, 5'd0));
    send(mk(OP_START_RD, 7'd5, 6'd63, 1'b1, 8'h00, 8'h00, 5'd0));
    // Two-byte write ending in a repeated start; load and start while busy are refused
    send(mk(OP_START_WR, 7'd127, 6'd2, 1'b0, 8'h00, 8'h00, 5'd0));
    send(mk(OP_LOAD, 7'd0, 6'd0, 1'b0, 8'h00, 8'hAA, 5'd2));
    send(mk(OP_START_RD, 7'd1, 6'd4, 1'b1, 8'h00, 8'h00, 5'd0));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_START, 8'h00, 5'd0));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_SLA_W_ACK, 8'h00, 5'd0));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_DATA_W_ACK, 8'h00, 5'd0));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_DATA_W_ACK, 8'h00, 5'd0));
    // Full-length read right after the repeated start: address goes out directly
    send(mk(OP_START_RD, 7'd0, 6'd32, 1'b1, 8'h00, 8'h00, 5'd0));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_REP_START, 8'h00, 5'd0));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_SLA_R_ACK, 8'h00, 5'd0));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_DATA_R_ACK, 8'hC3, 5'd0));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_DATA_R_NACK, 8'h3C, 5'd0));
    // Unknown opcodes, no-info code, status with low bits set
    send(mk(OP_UNUSED_LO, 7'd0, 6'd0, 1'b0, 8'h00, 8'h00, 5'd0));
    send(mk(OP_UNUSED_HI, 7'd127, 6'd63, 1'b1, 8'hFF, 8'hFF, 5'd31));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_NO_INFO, 8'h00, 5'd0));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_START | 8'h07, 8'h00, 5'd0));
    // Every error and abort code
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_SLA_W_NACK, 8'h00, 5'd0));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_DATA_W_NACK, 8'h00, 5'd0));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_ARB_LOST, 8'h00, 5'd0));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_BUS_ERR, 8'h00, 5'd0));
    send(mk(OP_STATUS, 7'd0, 6'd0, 1'b0, ST_SLA_R_NACK, 8'h00, 5'd0));
    send(mk(OP_READBACK, 7'd0, 6'd0, 1'b0, 8'h00, 8'h00, 5'd1));
    send(mk(OP_READBACK, 7'd0, 6'd0, 1'b0, 8'h00, 8'h00, 5'd0));
    drain();

    // Fill the whole buffer while idle so no later access can hit an unwritten slot
    random_base = sent;
    for (int s = 0; s < 32; s++) begin
      r = scramble(OP_LOAD);
      r.buffer_slot = 5'(s);
      send(r);
    end

    // Mostly well-formed transactions, plus read-backs and noise bursts
    while (sent < random_base + RandomItems) begin
      steady <= (sent >= random_base + 250) && (sent < random_base + 450);
      roll = $urandom_range(99);
      if (roll < 35) begin
        write_txn();
      end else if (roll < 70) begin
        read_txn();
      end else if (roll < 82) begin
        repeat ($urandom_range(1, 3)) send(scramble(OP_READBACK));
      end else begin
        repeat ($urandom_range(1, 4)) send(scramble(3'($urandom_range(7))));
        // Drop back to idle after noise half the time
        if ($urandom_range(1)) send(bus_evt(ST_SLA_R_NACK));
      end
      if ($urandom_range(39) == 0) drain();
    end

    // Wait for the last results, then let the pipeline settle
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d requests, checked %0d results: loads, read-backs, writes and reads",
             sent, checked);
    $display("with stops and repeated starts, nacks, arbitration loss, bus errors, overflow.");
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/i2cms_pkg.sv
hdl/i2cms_buffer.sv
hdl/i2cms_ctrl.sv
hdl/i2c_master_transaction_sequencer_unit.sv
tb/i2cms_txn_checker.sv
tb/testbench.sv
